### rtl/core/crs_pkg.sv
// shared types and codes for the clip rectangle stack
package crs_pkg;

    // operation codes of an input beat
    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2
    } op_t;

    // action codes of a result beat
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    // one stored clip rectangle
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } rect_t;

    // margin past the screen edge for an empty clip
    localparam logic [15:0] OFFSCREEN_MARGIN = 16'd16;

    // register indexes of the configuration port
    localparam logic [0:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [0:0] REG_SCREEN_HEIGHT = 1'd1;

endpackage

### rtl/core/clip_rectangle_stack.sv
// nested clip rectangle stack: push, pop and reset with intersection against the top
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, op, rect_x..rect_h    beat into the block
//   out      out_valid, out_stall, action..stack_level beat out of the block
//   cfg      cfg_write, cfg_index, cfg_data            register write, no handshake
//
// one beat per cycle sustained while out_stall is low; a taken beat goes to the output
// through the input register, then the stack update loads the result register
// the current top rectangle lives in flip-flops; the entry below it is prefetched
// from the stack memory every cycle so a pop need not wait for a memory read
// rst_n clears the level count and both valid flags; no memory clearing is needed
// a stalled output holds its beat while the input register still takes one more beat
module clip_rectangle_stack
    import crs_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic signed [15:0] rect_w,
    input  logic signed [15:0] rect_h,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         action,
    output logic signed [15:0] clip_x,
    output logic signed [15:0] clip_y,
    output logic [14:0]        clip_w,
    output logic [14:0]        clip_h,
    output logic [4:0]         stack_level
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);
    localparam logic [LW-1:0] LEVEL_ONE  = LW'(1);
    localparam logic [LW-1:0] LEVEL_TWO  = LW'(2);

    // configuration registers
    logic [14:0] screen_width_reg;
    logic [14:0] screen_height_reg;

    // input register
    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg;
    logic signed [15:0] s1_x_reg;
    logic signed [15:0] s1_y_reg;
    logic signed [15:0] s1_w_reg;
    logic signed [15:0] s1_h_reg;

    // stack state
    rect_t           mem [STACK_DEPTH];
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;
    rect_t           top_reg;
    rect_t           top_next;
    rect_t           below_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [LW-1:0]   rd_level;

    // result register
    logic            out_valid_reg;
    action_t         action_reg;
    action_t         action_next;
    rect_t           res_reg;
    rect_t           res_next;
    logic [LW-1:0]   level_out_reg;
    logic [31:0]     level_wide;

    logic            advance;
    logic            take_in;

    // push arithmetic
    logic signed [15:0] push_w;
    logic signed [15:0] push_h;
    logic signed [15:0] ix1;
    logic signed [15:0] iy1;
    logic signed [17:0] top_right;
    logic signed [17:0] top_bottom;
    logic signed [17:0] new_right;
    logic signed [17:0] new_bottom;
    logic signed [17:0] ix2;
    logic signed [17:0] iy2;
    logic signed [17:0] iw;
    logic signed [17:0] ih;
    rect_t              push_rect;
    rect_t              isect_rect;

    // handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= 15'd1920;
            screen_height_reg <= 15'd1080;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take_in || advance)
        begin
            s1_valid_reg <= take_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_op_reg <= op;
            s1_x_reg  <= rect_x;
            s1_y_reg  <= rect_y;
            s1_w_reg  <= rect_w;
            s1_h_reg  <= rect_h;
        end
    end

    // raise size to at least one pixel
    assign push_w = (s1_w_reg < 16'sd1) ? 16'sd1 : s1_w_reg;
    assign push_h = (s1_h_reg < 16'sd1) ? 16'sd1 : s1_h_reg;

    // intersection with the current top, edges taken wide
    always_comb
    begin
        push_rect.x = s1_x_reg;
        push_rect.y = s1_y_reg;
        push_rect.w = push_w[14:0];
        push_rect.h = push_h[14:0];

        ix1 = (top_reg.x > s1_x_reg) ? top_reg.x : s1_x_reg;
        iy1 = (top_reg.y > s1_y_reg) ? top_reg.y : s1_y_reg;
        top_right  = 18'(top_reg.x) + $signed({3'b000, top_reg.w});
        top_bottom = 18'(top_reg.y) + $signed({3'b000, top_reg.h});
        new_right  = 18'(s1_x_reg) + 18'(push_w);
        new_bottom = 18'(s1_y_reg) + 18'(push_h);
        ix2 = (top_right < new_right) ? top_right : new_right;
        iy2 = (top_bottom < new_bottom) ? top_bottom : new_bottom;
        iw  = ix2 - 18'(ix1);
        ih  = iy2 - 18'(iy1);

        if (iw <= 18'sd0 || ih <= 18'sd0)
        begin
            isect_rect.x = 16'({1'b0, screen_width_reg}) + OFFSCREEN_MARGIN;
            isect_rect.y = 16'({1'b0, screen_height_reg}) + OFFSCREEN_MARGIN;
            isect_rect.w = 15'd1;
            isect_rect.h = 15'd1;
        end
        else
        begin
            isect_rect.x = ix1;
            isect_rect.y = iy1;
            isect_rect.w = iw[14:0];
            isect_rect.h = ih[14:0];
        end
    end

    // stack update and result for the beat in the input register
    always_comb
    begin
        level_next  = level_reg;
        top_next    = top_reg;
        action_next = ACT_NONE;
        res_next    = '0;
        mem_we      = 1'b0;

        if (s1_valid_reg && advance)
        begin
            unique case (s1_op_reg)
                OP_RESET:
                begin
                    if (level_reg != '0)
                    begin
                        level_next  = '0;
                        action_next = ACT_END;
                    end
                end
                OP_PUSH:
                begin
                    res_next    = (level_reg != '0) ? isect_rect : push_rect;
                    action_next = ACT_BEGIN;
                    if (level_reg < LEVEL_FULL)
                    begin
                        mem_we     = 1'b1;
                        top_next   = res_next;
                        level_next = level_reg + LEVEL_ONE;
                    end
                end
                OP_POP:
                begin
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - LEVEL_ONE;
                        if (level_reg == LEVEL_ONE)
                        begin
                            action_next = ACT_END;
                        end
                        else
                        begin
                            action_next = ACT_BEGIN;
                            res_next    = below_reg;
                            top_next    = below_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // prefetch the entry under the next top
    assign rd_level = level_next - LEVEL_TWO;
    assign rd_addr  = rd_level[AW-1:0];

    // stack memory, written at the level, read one below the next top
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[level_reg[AW-1:0]] <= res_next;
        end
        below_reg <= mem[rd_addr];
    end

    // stack control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            action_reg    <= action_next;
            res_reg       <= res_next;
            level_out_reg <= level_next;
        end
    end

    // output beat
    assign level_wide  = 32'(level_out_reg);
    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign clip_x      = res_reg.x;
    assign clip_y      = res_reg.y;
    assign clip_w      = res_reg.w;
    assign clip_h      = res_reg.h;
    assign stack_level = level_wide[4:0];

endmodule
